/* rtl/qoi_pkg.sv */
// ---------------------------------------------------------------------------
// QOI decoder package
// Shared types and chunk codes for the QOI chunk-stream decoder.
// ---------------------------------------------------------------------------
package qoi_pkg;

   localparam logic [7:0] OP_RGB  = 8'hfe;
   localparam logic [7:0] OP_RGBA = 8'hff;
   localparam logic [1:0] TAG_INDEX = 2'b00;
   localparam logic [1:0] TAG_DIFF  = 2'b01;
   localparam logic [1:0] TAG_LUMA  = 2'b10;
   localparam logic [1:0] TAG_RUN   = 2'b11;
   localparam logic [31:0] PIXEL_RESET = 32'hff000000;
   localparam int INDEX_BITS = 6;

   // controller to datapath
   typedef struct packed {
      logic clear;      // clear image state (index, pixel, chunk, position)
      logic take_byte;  // decode accepted byte into the pixel
      logic load_out;   // load output register from current pixel
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       pixel_made; // the byte just taken completed a chunk
      logic [6:0] count;      // pixels that chunk asks for
      logic       image_done;
      logic       last_pos;   // current position is last of image
      logic       need_fetch; // byte on the port is an index op, read first
   } dp_status_type;

endpackage

/* rtl/qoi_datapath.sv */
// ---------------------------------------------------------------------------
// QOI decoder datapath
// Chunk assembly, colour index, current pixel, position counters and the
// output register.
// ---------------------------------------------------------------------------
module qoi_datapath #(
   parameter int DIMENSION_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic                       csr_index,
   input  logic [DIMENSION_BITS-1:0]  csr_data,
   input  logic [7:0]                 byte_in,
   input  qoi_pkg::dp_cmd_type        cmd,
   output qoi_pkg::dp_status_type     status,
   output logic [31:0]                out_pixel,
   output logic                       out_row_end,
   output logic                       out_image_end
);
   import qoi_pkg::*;

   logic [DIMENSION_BITS-1:0] width_ff, height_ff, col_ff, col_in, row_ff, row_in;
   logic [31:0] pix_ff, pix_in;
   logic [7:0]  opc_ff, opc_in;
   logic [2:0]  pend_ff, pend_in;
   logic [23:0] gath_ff, gath_in;
   logic        done_ff, done_in;
   logic [63:0] valid_ff, valid_in;
   logic [31:0] index_mem [64];
   logic [31:0] rd_ff;
   logic        rdv_ff;
   logic [31:0] out_ff;
   logic        rend_ff, iend_ff;
   logic [DIMENSION_BITS-1:0] w_lim, h_lim;
   logic        re, ie, made;
   logic [6:0]  count;
   logic [31:0] idx_rd;
   logic [7:0]  r, g, b, a, vg;
   logic [INDEX_BITS-1:0] hash;
   logic [9:0]  hsum;

   // dimension registers, zero acts as one
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIMENSION_BITS'(1);
         height_ff <= DIMENSION_BITS'(1);
      end else if (csr_write) begin
         if (csr_index) height_ff <= csr_data;
         else           width_ff  <= csr_data;
      end
   end
   assign w_lim = (width_ff  == '0) ? '0 : width_ff  - DIMENSION_BITS'(1);
   assign h_lim = (height_ff == '0) ? '0 : height_ff - DIMENSION_BITS'(1);
   assign re = col_ff >= w_lim;
   assign ie = re && (row_ff >= h_lim);

   // index read data from the cycle before, entry not yet written reads zero
   assign idx_rd = rdv_ff ? rd_ff : '0;

   // chunk decode
   always_comb begin
      r = pix_ff[7:0]; g = pix_ff[15:8]; b = pix_ff[23:16]; a = pix_ff[31:24];
      vg = 8'({2'b00, opc_ff[5:0]}) - 8'd32;
      made = 1'b0;
      count = 7'd1;
      opc_in = opc_ff; pend_in = pend_ff; gath_in = gath_ff;
      if (pend_ff != 3'd0) begin
         pend_in = pend_ff - 3'd1;
         if (pend_in != 3'd0) begin
            gath_in = {gath_ff[15:0], byte_in};
         end else begin
            made = 1'b1;
            gath_in = '0;
            if (opc_ff == OP_RGB) begin
               r = gath_ff[15:8]; g = gath_ff[7:0]; b = byte_in;
            end else if (opc_ff == OP_RGBA) begin
               r = gath_ff[23:16]; g = gath_ff[15:8]; b = gath_ff[7:0]; a = byte_in;
            end else begin
               r = r + vg - 8'd8 + {4'd0, byte_in[7:4]};
               g = g + vg;
               b = b + vg - 8'd8 + {4'd0, byte_in[3:0]};
            end
         end
      end else if (byte_in == OP_RGB || byte_in == OP_RGBA) begin
         opc_in = byte_in;
         pend_in = (byte_in == OP_RGB) ? 3'd3 : 3'd4;
         gath_in = '0;
      end else begin
         case (byte_in[7:6])
            TAG_LUMA: begin
               opc_in = byte_in; pend_in = 3'd1; gath_in = '0;
            end
            TAG_INDEX: begin
               made = 1'b1;
               {a, b, g, r} = idx_rd;
            end
            TAG_DIFF: begin
               made = 1'b1;
               r = r + {6'd0, byte_in[5:4]} - 8'd2;
               g = g + {6'd0, byte_in[3:2]} - 8'd2;
               b = b + {6'd0, byte_in[1:0]} - 8'd2;
            end
            default: begin
               made = 1'b1;
               count = {1'b0, byte_in[5:0]} + 7'd1;
            end
         endcase
      end
   end

   assign hsum = 10'(r) * 10'd3 + 10'(g) * 10'd5 + 10'(b) * 10'd7 + 10'(a) * 10'd11;
   assign hash = hsum[INDEX_BITS-1:0];

   // state update
   always_comb begin
      pix_in = pix_ff; col_in = col_ff; row_in = row_ff; done_in = done_ff;
      valid_in = valid_ff;
      if (cmd.take_byte && made) begin
         pix_in = {a, b, g, r};
         valid_in[hash] = 1'b1;
      end
      if (cmd.load_out) begin
         if (re) begin
            col_in = '0;
            if (ie) done_in = 1'b1;
            else    row_in = row_ff + DIMENSION_BITS'(1);
         end else begin
            col_in = col_ff + DIMENSION_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         pix_ff <= PIXEL_RESET; opc_ff <= '0; pend_ff <= '0; gath_ff <= '0;
         col_ff <= '0; row_ff <= '0; done_ff <= 1'b0; valid_ff <= '0;
      end else begin
         pix_ff <= pix_in; col_ff <= col_in; row_ff <= row_in; done_ff <= done_in;
         valid_ff <= valid_in;
         if (cmd.take_byte) begin
            opc_ff <= opc_in; pend_ff <= pend_in; gath_ff <= gath_in;
         end
      end
   end

   // colour index memory
   always_ff @(posedge clock) begin
      if (cmd.take_byte && made) index_mem[hash] <= {a, b, g, r};
   end

   // registered index read at the address on the port
   always_ff @(posedge clock) begin
      rd_ff  <= index_mem[byte_in[5:0]];
      rdv_ff <= valid_ff[byte_in[5:0]];
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff  <= pix_ff;
         rend_ff <= re;
         iend_ff <= ie;
      end
   end

   assign status.pixel_made = made;
   assign status.count      = count;
   assign status.image_done = done_ff;
   assign status.last_pos   = ie;
   assign status.need_fetch = (pend_ff == 3'd0) && (byte_in[7:6] == TAG_INDEX);
   assign out_pixel     = out_ff;
   assign out_row_end   = rend_ff;
   assign out_image_end = iend_ff;

endmodule

/* rtl/qoi_control.sv */
// ---------------------------------------------------------------------------
// QOI decoder controller
// Accepts bytes, sequences the pixels of each chunk or run onto the output.
// ---------------------------------------------------------------------------
module qoi_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_image_start,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_run_last,
   input  qoi_pkg::dp_status_type  status,
   output qoi_pkg::dp_cmd_type     cmd
);
   import qoi_pkg::*;

   typedef enum logic [1:0] {S_TAKE, S_START, S_FETCH, S_EMIT} state_type;

   state_type   state_ff, state_in;
   logic [6:0]  left_ff, left_in;
   logic        valid_ff, valid_in, last_ff, last_in;
   logic        out_free, more;

   assign out_free = !valid_ff || rsp_ready;

   // a byte waits on the port while the state is cleared or an index entry is read
   always_comb begin
      case (state_ff)
         S_TAKE:  req_ready = !req_image_start &&
                              (status.image_done || !status.need_fetch);
         S_START: req_ready = !status.need_fetch;
         S_FETCH: req_ready = 1'b1;
         default: req_ready = 1'b0;
      endcase
   end

   // S_TAKE: accept byte; image start clears first (S_START), index op reads first (S_FETCH)
   always_comb begin
      state_in = state_ff; left_in = left_ff;
      valid_in = valid_ff && !rsp_ready; last_in = last_ff;
      cmd = '0;
      more = 1'b0;
      case (state_ff)
         S_TAKE: begin
            if (req_valid) begin
               if (req_image_start) begin
                  cmd.clear = 1'b1;
                  state_in = S_START;
               end else if (!status.image_done) begin
                  if (status.need_fetch) begin
                     state_in = S_FETCH;
                  end else begin
                     cmd.take_byte = 1'b1;
                     if (status.pixel_made) begin
                        left_in = status.count;
                        state_in = S_EMIT;
                     end
                  end
               end
            end
         end
         S_START: begin
            // byte held back is still on the port, since ready was low
            if (status.need_fetch) begin
               state_in = S_FETCH;
            end else begin
               cmd.take_byte = 1'b1;
               if (status.pixel_made) begin
                  left_in = status.count;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_TAKE;
               end
            end
         end
         S_FETCH: begin
            // index entry now read, byte taken
            cmd.take_byte = 1'b1;
            if (status.pixel_made) begin
               left_in = status.count;
               state_in = S_EMIT;
            end else begin
               state_in = S_TAKE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               more = (left_ff != 7'd1) && !status.last_pos;
               valid_in = 1'b1;
               last_in = !more;
               left_in = left_ff - 7'd1;
               if (!more) state_in = S_TAKE;
            end
         end
         default: state_in = S_TAKE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_TAKE; left_ff <= '0;
         valid_ff <= 1'b0; last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; left_ff <= left_in;
         valid_ff <= valid_in; last_ff <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_run_last = last_ff;

endmodule

/* rtl/qoi_image_decoder_core.sv */
// ---------------------------------------------------------------------------
// QOI image decoder core
// Decodes the chunk stream of a QOI image into RGBA pixels.
// ---------------------------------------------------------------------------
// One byte is taken per cycle while it does not complete a chunk. A byte
// that completes a chunk then holds the input while its pixels (one, or up
// to 62 for a run) go out one at a time through the single output
// register, and while the result side stalls. An index byte also waits
// for the colour index read, and a byte with image_start set for the
// state clear. Bytes after the last pixel of the image are taken and
// dropped until image_start.
module qoi_image_decoder_core #(
   parameter int DIMENSION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [DIMENSION_BITS-1:0] csr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_image_start,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic [7:0]                rsp_alpha,
   output logic                      rsp_run_last,
   output logic                      rsp_row_end,
   output logic                      rsp_image_end
);
   import qoi_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [31:0]   pixel;

   qoi_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_image_start,
      .rsp_valid, .rsp_ready, .rsp_run_last, .status, .cmd
   );

   qoi_datapath #(.DIMENSION_BITS(DIMENSION_BITS)) u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .byte_in(req_data_byte), .cmd, .status,
      .out_pixel(pixel), .out_row_end(rsp_row_end), .out_image_end(rsp_image_end)
   );

   assign rsp_red   = pixel[7:0];
   assign rsp_green = pixel[15:8];
   assign rsp_blue  = pixel[23:16];
   assign rsp_alpha = pixel[31:24];

endmodule

/* rtl/qoi_checker.sv */
// ---------------------------------------------------------------------------
// QOI decoder port checker
// Port-level checks on the result channel.
// ---------------------------------------------------------------------------
module qoi_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_run_last,
   input logic rsp_row_end,
   input logic rsp_image_end
);
   // a stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp beat dropped");
   // image end is always a row end
   a_ie: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_end |-> rsp_row_end) else $error("image end without row end");
   // image end closes the run of its byte
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_end |-> rsp_run_last) else $error("pixels after image end");
   // no byte is taken while a run is still being issued
   a_nobyte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> !req_ready) else $error("byte taken mid run");
endmodule

bind qoi_image_decoder_core qoi_checker u_chk (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_run_last, .rsp_row_end, .rsp_image_end
);
